// ===== hdl/rqr_pkg.sv =====
// Package: payload structs, action codes and sequencer states for the ready queue.
package rqr_pkg;

  localparam int unsigned IdOutW  = 8;
  localparam int unsigned CountW  = 5;

  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IdOutW-1:0] thread_id;
  } in_t;

  typedef struct packed {
    logic              dispatch_valid;
    logic [IdOutW-1:0] dispatch_id;
    logic              found;
    logic              full_drop;
    logic [CountW-1:0] entry_count;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DISP  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

// ===== hdl/ready_queue_with_removal.sv =====
// Add or no-op goes straight to the result beat, dispatch first reads the head entry,
// and remove walks the n queued entries (one entry scanned or shifted per cycle).
// One item at a time: the next beat is taken in the cycle after the result moves to
// the output register.
// Reset clears count, head pointer and output valid; the entry memory keeps its contents
// and needs no clearing pass, since only data from slots below the count is ever used.
module ready_queue_with_removal #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rqr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rqr_pkg::out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  logic                res_valid;
  logic                res_take;
  rqr_pkg::out_t       res_data;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic [AddrW-1:0]    mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;

  logic          out_valid_q;
  rqr_pkg::out_t out_q;

  // Sequencer: holds the circular-buffer pointers and walks the store on remove.
  rqr_ctrl #(
    .QueueDepth (QUEUE_DEPTH),
    .IdWidth    (ID_WIDTH),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_take_i  (res_take),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .wdata_o     (mem_wdata),
    .raddr_o     (mem_raddr),
    .rdata_i     (mem_rdata)
  );

  // Entry store, one write and one read per cycle.
  rqr_ram #(
    .Depth (QUEUE_DEPTH),
    .Width (ID_WIDTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: take a finished result when the slot is empty or draining.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload holds while the beat is stalled.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every accepted beat puts the sequencer to work, so the input stalls behind it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after accept");

  // A result reports at most one kind of event.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.dispatch_valid && out_data_o.found) &&
                    !(out_data_o.dispatch_valid && out_data_o.full_drop) &&
                    !(out_data_o.found && out_data_o.full_drop))
    else $error("result flags more than one event");

  // No dispatch means a zero identifier.
  a_disp_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.dispatch_valid) |-> (out_data_o.dispatch_id == '0))
    else $error("dispatch id set without dispatch");

endmodule

// ===== hdl/rqr_ram.sv =====
// Entry store: one write port, one read port with registered read data.
module rqr_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/rqr_ctrl.sv =====
// Sequencer: circular-buffer pointers, id compare for remove and remove/compact walk.
module rqr_ctrl #(
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned IdWidth    = 8,
  parameter int unsigned AddrW      = 4,
  parameter int unsigned CntW       = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rqr_pkg::in_t        in_data_i,
  output logic                res_valid_o,
  output rqr_pkg::out_t       res_data_o,
  input  logic                res_take_i,
  output logic                we_o,
  output logic [AddrW-1:0]    waddr_o,
  output logic [IdWidth-1:0]  wdata_o,
  output logic [AddrW-1:0]    raddr_o,
  input  logic [IdWidth-1:0]  rdata_i
);

  localparam logic [AddrW:0]  DepthW = (AddrW+1)'(QueueDepth);
  localparam logic [CntW-1:0] FullC  = CntW'(QueueDepth);

  rqr_pkg::state_e state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [AddrW-1:0]   head_q, head_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [IdWidth-1:0] id_q, id_d;
  logic [IdWidth-1:0] did_q, did_d;
  logic               dvalid_q, dvalid_d;
  logic               found_q, found_d;
  logic               drop_q, drop_d;

  logic                       accept;
  logic [IdWidth+IdWidth-1:0] id_ext;
  logic [IdWidth-1:0]         id_in;
  logic [CntW-1:0]            cnt_m1;
  logic [AddrW-1:0]           last_pos;
  logic [AddrW-1:0]           pos_p1;
  logic                       at_last;
  logic [CntW+rqr_pkg::CountW-1:0] cnt_ext;
  logic [IdWidth+rqr_pkg::IdOutW-1:0] did_ext;

  // Map a logical position from the head to a physical slot.
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [AddrW-1:0] p);
    logic [AddrW:0] s;
    s = {1'b0, head} + {1'b0, p};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[AddrW-1:0];
  endfunction

  assign accept   = in_valid_i && !in_stall_o;
  assign id_ext   = {{IdWidth{1'b0}}, in_data_i.thread_id};
  assign id_in    = id_ext[IdWidth-1:0];
  assign cnt_m1   = count_q - CntW'(1);
  assign last_pos = cnt_m1[AddrW-1:0];
  assign pos_p1   = pos_q + AddrW'(1);
  assign at_last  = (pos_q == last_pos);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    head_d   = head_q;
    pos_d    = pos_q;
    id_d     = id_q;
    did_d    = did_q;
    dvalid_d = dvalid_q;
    found_d  = found_q;
    drop_d   = drop_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = rdata_i;
    raddr_o  = head_q;
    case (state_q)
      rqr_pkg::ST_IDLE: begin
        if (accept) begin
          id_d     = id_in;
          did_d    = '0;
          dvalid_d = 1'b0;
          found_d  = 1'b0;
          drop_d   = 1'b0;
          pos_d    = '0;
          state_d  = rqr_pkg::ST_DONE;
          case (in_data_i.action)
            rqr_pkg::ACT_ADD: begin
              if (count_q == FullC) begin
                drop_d = 1'b1;
              end else begin
                we_o    = 1'b1;
                waddr_o = phys(head_q, count_q[AddrW-1:0]);
                wdata_o = id_in;
                count_d = count_q + CntW'(1);
              end
            end
            rqr_pkg::ACT_DISPATCH: begin
              if (count_q != '0) begin
                state_d = rqr_pkg::ST_DISP;
              end
            end
            rqr_pkg::ACT_REMOVE: begin
              if (count_q != '0) begin
                state_d = rqr_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      rqr_pkg::ST_DISP: begin
        // Head data is back: pop it.
        dvalid_d = 1'b1;
        did_d    = rdata_i;
        head_d   = phys(head_q, AddrW'(1));
        count_d  = cnt_m1;
        state_d  = rqr_pkg::ST_DONE;
      end
      rqr_pkg::ST_SCAN: begin
        raddr_o = phys(head_q, pos_p1);
        if (rdata_i == id_q) begin
          found_d = 1'b1;
          if (at_last) begin
            count_d = cnt_m1;
            state_d = rqr_pkg::ST_DONE;
          end else begin
            pos_d   = pos_p1;
            state_d = rqr_pkg::ST_SHIFT;
          end
        end else if (at_last) begin
          state_d = rqr_pkg::ST_DONE;
        end else begin
          pos_d = pos_p1;
        end
      end
      rqr_pkg::ST_SHIFT: begin
        // Move entry at pos one slot toward the head.
        raddr_o = phys(head_q, pos_p1);
        we_o    = 1'b1;
        waddr_o = phys(head_q, pos_q - AddrW'(1));
        wdata_o = rdata_i;
        if (at_last) begin
          count_d = cnt_m1;
          state_d = rqr_pkg::ST_DONE;
        end else begin
          pos_d = pos_p1;
        end
      end
      rqr_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = rqr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rqr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rqr_pkg::ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    id_q     <= id_d;
    did_q    <= did_d;
    dvalid_q <= dvalid_d;
    found_q  <= found_d;
    drop_q   <= drop_d;
  end

  assign cnt_ext = {{rqr_pkg::CountW{1'b0}}, count_q};
  assign did_ext = {{rqr_pkg::IdOutW{1'b0}}, did_q};

  assign in_stall_o  = (state_q != rqr_pkg::ST_IDLE);
  assign res_valid_o = (state_q == rqr_pkg::ST_DONE);

  always_comb begin
    res_data_o.dispatch_valid = dvalid_q;
    res_data_o.dispatch_id    = did_ext[rqr_pkg::IdOutW-1:0];
    res_data_o.found          = found_q;
    res_data_o.full_drop      = drop_q;
    res_data_o.entry_count    = cnt_ext[rqr_pkg::CountW-1:0];
  end

endmodule

// ===== tb/ready_queue_checker.sv =====
// Scoreboard for the ready queue: tracks the queued ids, predicts each result beat, compares.
module ready_queue_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rqr_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rqr_pkg::out_t out_data_i,
  output int unsigned   due_count_o,
  output int unsigned   fail_count_o
);
  import rqr_pkg::*;

  localparam logic [IdOutW-1:0] IdMask = IdOutW'((64'd1 << ID_WIDTH) - 64'd1);

  logic [IdOutW-1:0] ready_ids[$];
  out_t              results_due[$];

  // Apply one scheduler action to the shadow queue and build the result it yields.
  function automatic out_t schedule_step(input in_t beat);
    out_t              res;
    logic [IdOutW-1:0] tid;
    int                hit;
    res = '0;
    tid = beat.thread_id & IdMask;
    hit = -1;
    case (beat.action)
      ACT_ADD: begin
        if (ready_ids.size() >= QUEUE_DEPTH) res.full_drop = 1'b1;
        else ready_ids.push_back(tid);
      end
      ACT_DISPATCH: begin
        if (ready_ids.size() > 0) begin
          res.dispatch_valid = 1'b1;
          res.dispatch_id    = ready_ids.pop_front();
        end
      end
      ACT_REMOVE: begin
        foreach (ready_ids[i]) if (hit < 0 && ready_ids[i] == tid) hit = i;
        if (hit >= 0) begin
          ready_ids.delete(hit);
          res.found = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = CountW'(ready_ids.size());
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      ready_ids.delete();
      results_due.delete();
      due_count_o  = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat %h with nothing outstanding", out_data_i);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          check_field("dispatch_valid", want.dispatch_valid, out_data_i.dispatch_valid);
          check_field("dispatch_id", want.dispatch_id, out_data_i.dispatch_id);
          check_field("found", want.found, out_data_i.found);
          check_field("full_drop", want.full_drop, out_data_i.full_drop);
          check_field("entry_count", want.entry_count, out_data_i.entry_count);
        end
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(schedule_step(in_data_i));
      due_count_o = results_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the ready queue testbench: clock, reset, stimulus, stall control and the verdict.
module tb_top;
  import rqr_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdWidth    = 8;
  // no action code 3 in the package; the block must treat it as a no-op
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  // cycles without any beat before the run is declared hung
  localparam int unsigned QuietLimit = 2000;
  // settle time after the last result: longer than a full-depth remove
  localparam int unsigned TailCycles = 2 * QueueDepth + 8;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  int unsigned due_count;
  int unsigned fail_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  ready_queue_with_removal #(
    .QUEUE_DEPTH(QueueDepth),
    .ID_WIDTH   (IdWidth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  ready_queue_checker #(
    .QUEUE_DEPTH(QueueDepth),
    .ID_WIDTH   (IdWidth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .due_count_o (due_count),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side: stall the result channel at random, redrawn every cycle.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // Hang detector: count cycles in which neither channel moves a beat; bail out at the limit.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic in_t make_beat(input logic [1:0] act, input logic [IdOutW-1:0] tid);
    in_t b;
    b.action    = act;
    b.thread_id = tid;
    return b;
  endfunction

  // Draw one scheduler action. Fill-heavy stretches push the queue to full so adds get
  // dropped; drain-heavy stretches empty it so dispatch and remove hit the empty queue.
  function automatic in_t random_beat(input bit fill_heavy);
    in_t         b;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < (fill_heavy ? 60 : 25))      b.action = ACT_ADD;
    else if (roll < (fill_heavy ? 75 : 60)) b.action = ACT_DISPATCH;
    else if (roll < 96)                     b.action = ACT_REMOVE;
    else                                    b.action = ACT_UNUSED;
    // most ids come from a pool of sixteen (0x00, 0x11 .. 0xFF) so removes often find a
    // match and duplicates pile up; the rest cover the whole id range
    if ($urandom_range(3) != 0) b.thread_id = IdOutW'(8'h11 * $urandom_range(15));
    else                        b.thread_id = IdOutW'($urandom_range(255));
    return b;
  endfunction

  // Send one beat. Enter and leave at a falling edge; valid stays high into the next
  // beat unless a gap is drawn, so it is never lowered and raised in the same step.
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    // hold the payload until the block takes it
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
  endtask

  task automatic run_random(input int unsigned n_beats, input int unsigned send_pct,
                            input int unsigned recv_pct);
    bit fill_heavy;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    fill_heavy    = 1'b1;
    for (int k = 0; k < n_beats; k++) begin
      // redraw filling or draining every couple dozen beats
      if (k % 24 == 0) fill_heavy = $urandom_range(1);
      send_beat(random_beat(fill_heavy));
    end
  endtask

  initial begin : stimulus
    logic [IdOutW-1:0] fill_ids[16];
    fill_ids = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h5A, 8'h01, 8'h02, 8'h04,
                 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE, 8'h33};

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-queue corners first, then the unused action code.
    send_beat(make_beat(ACT_DISPATCH, 8'hFF));
    send_beat(make_beat(ACT_REMOVE, 8'h00));
    send_beat(make_beat(ACT_UNUSED, 8'hAA));
    // fill to the brim, with a duplicate id in the middle
    foreach (fill_ids[i]) send_beat(make_beat(ACT_ADD, fill_ids[i]));
    // add to a full queue: dropped
    send_beat(make_beat(ACT_ADD, 8'hC3));
    // remove the first of two equal ids, a miss, the tail and the head
    send_beat(make_beat(ACT_REMOVE, 8'h5A));
    send_beat(make_beat(ACT_REMOVE, 8'h99));
    send_beat(make_beat(ACT_REMOVE, 8'h33));
    send_beat(make_beat(ACT_REMOVE, 8'hFF));
    send_beat(make_beat(ACT_DISPATCH, 8'h00));
    send_beat(make_beat(ACT_UNUSED, 8'h55));
    hold_until_drained();

    // Random: slow receiver first, then slow sender, then full speed both ways.
    run_random(150, 32, 68);
    hold_until_drained();
    run_random(150, 68, 32);
    hold_until_drained();
    run_random(150, 0, 0);
    hold_until_drained();

    // let any stray result beat surface before the verdict
    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
